@@ hdl/wpp_pkg.sv @@
// ----------------------------------------------------------------------------
// wpp_pkg: shared types and constants for the waveform peak pyramid
// Bucket layout, cell control/status groups, sizes and register map.
// ----------------------------------------------------------------------------
package wpp_pkg;

  // Pyramid shape (FOLD must be a power of two)
  localparam int BASE_FRAMES = 256;
  localparam int FOLD        = 4;
  localparam int LEVELS      = 8;
  localparam int NUM_LANES   = 3;

  // Field widths
  localparam int SAMPLE_W = 16;
  localparam int SQ_W     = 53;
  localparam int CNT_W    = 23;
  localparam int TOTAL_W  = 32;
  localparam int LEVEL_W  = 3;
  localparam int LANE_W   = 2;
  localparam int CC_W     = 2;

  localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int FOLD_W = $clog2(FOLD);
  localparam int PCNT_W = TOTAL_W + 1;

  // Command codes
  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Register map (word index = paddr[APB_AW-1:2])
  localparam int                APB_AW            = 3;
  localparam int                APB_DW            = 32;
  localparam logic [APB_AW-3:0] REG_CHANNEL_COUNT = '0;
  localparam logic [CC_W-1:0]   CC_RESET          = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mn;
    logic signed [SAMPLE_W-1:0] mx;
    logic [SQ_W-1:0]            sq;
    logic [CNT_W-1:0]           n;
  } bucket_t;

  // Bucket handed into a cell for merging
  typedef struct packed {
    logic              valid;
    logic [LANE_W-1:0] lane;
    bucket_t           bkt;
  } merge_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic              emit;
    logic [LANE_W-1:0] lane;
    logic              bump;
    logic              clr;
  } cell_ctl_t;

  // Per-cell status back to the sequencer
  typedef struct packed {
    logic               nonempty;
    logic               full;
    logic [TOTAL_W-1:0] totals;
  } cell_stat_t;

endpackage

@@ hdl/wpp_ifs.sv @@
// ----------------------------------------------------------------------------
// wpp_ifs: valid/ready channel interfaces of the waveform peak pyramid
// Frame channel (commands and samples in) and bucket channel (results out).
// ----------------------------------------------------------------------------
interface wpp_frame_if import wpp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       cmd;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;

  modport source (output valid, output cmd, output left_sample, output right_sample,
                  input ready);
  modport sink   (input valid, input cmd, input left_sample, input right_sample,
                  output ready);
endinterface

interface wpp_bucket_if import wpp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [LEVEL_W-1:0]         level;
  logic [LANE_W-1:0]          lane;
  logic signed [SAMPLE_W-1:0] bucket_min;
  logic signed [SAMPLE_W-1:0] bucket_max;
  logic [SQ_W-1:0]            square_sum;
  logic [CNT_W-1:0]           frame_count;
  logic                       last;

  modport source (output valid, output level, output lane, output bucket_min,
                  output bucket_max, output square_sum, output frame_count, output last,
                  input ready);
  modport sink   (input valid, input level, input lane, input bucket_min,
                  input bucket_max, input square_sum, input frame_count, input last,
                  output ready);
endinterface

@@ hdl/wpp_cell.sv @@
// ----------------------------------------------------------------------------
// wpp_cell: one pyramid level
// Holds the running bucket of each lane and the count of complete buckets.
// Merges a bucket from its left neighbor, and hands an emitted bucket to the
// right neighbor while clearing it.
// ----------------------------------------------------------------------------
module wpp_cell import wpp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctl_t  ctl,
  input  merge_t     merge_in,
  output bucket_t    emit_bkt,
  output cell_stat_t stat
);

  bucket_t            acc [NUM_LANES];
  logic [TOTAL_W-1:0] totals;

  bucket_t       dst;
  bucket_t       merged;
  logic [SQ_W:0]  sq_sum;
  logic [CNT_W:0] n_sum;

  // Lane reads: merge target and emitted bucket (an empty emitted bucket reads as zero)
  always_comb begin
    dst      = '0;
    emit_bkt = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (merge_in.lane == LANE_W'(i)) dst = acc[i];
      if (ctl.lane == LANE_W'(i) && acc[i].n != '0) emit_bkt = acc[i];
    end
  end

  // Merge with saturating sums
  always_comb begin
    sq_sum = {1'b0, dst.sq} + {1'b0, merge_in.bkt.sq};
    n_sum  = {1'b0, dst.n} + {1'b0, merge_in.bkt.n};
    merged = dst;
    if (dst.n == '0) begin
      merged = merge_in.bkt;
    end else begin
      if ($signed(merge_in.bkt.mn) < $signed(dst.mn)) merged.mn = merge_in.bkt.mn;
      if ($signed(merge_in.bkt.mx) > $signed(dst.mx)) merged.mx = merge_in.bkt.mx;
      merged.sq = sq_sum[SQ_W] ? '1 : sq_sum[SQ_W-1:0];
      merged.n  = n_sum[CNT_W] ? '1 : n_sum[CNT_W-1:0];
    end
  end

  // Bucket storage; a zero count marks an empty bucket
  always_ff @(posedge clk) begin
    if (rst || ctl.clr) begin
      for (int i = 0; i < NUM_LANES; i++) acc[i].n <= '0;
      totals <= '0;
    end else begin
      for (int i = 0; i < NUM_LANES; i++) begin
        if (ctl.emit && ctl.lane == LANE_W'(i)) begin
          acc[i].n <= '0;
        end else if (merge_in.valid && merge_in.bkt.n != '0 &&
                     merge_in.lane == LANE_W'(i)) begin
          acc[i] <= merged;
        end
      end
      if (ctl.bump) totals <= totals + TOTAL_W'(1);
    end
  end

  assign stat.nonempty = (acc[0].n != '0);
  assign stat.full     = (acc[0].n == CNT_W'(BASE_FRAMES));
  assign stat.totals   = totals;

endmodule

@@ hdl/waveform_peak_pyramid_top.sv @@
// ----------------------------------------------------------------------------
// waveform_peak_pyramid_top: min/max/RMS overview pyramid of an audio stream
//
// Frame channel: cmd 0 carries one frame (left, right Q1.15), cmd 1 flushes
// the trailing partial buckets and empties the pyramid. Bucket channel: one
// transaction per emitted bucket, level by level, lanes ascending; last marks
// the final bucket caused by a frame transaction.
// A frame is squared, then merged into level 0, lane by lane; a check state
// follows, and the frame is accepted in the idle state. Each emitted bucket
// passes through the emit state. A flush plans the levels in turn, emits
// each bucket or skips the level, and ends in a clear state.
// The level cells form a chain; each emitted bucket merges into the next
// cell in the same cycle.
// A stalled receiver holds the bucket register and keeps the sequencer from emitting further buckets.
// Reset empties all levels, sets channel_count to two; a write to
// channel_count also empties the pyramid.
// ----------------------------------------------------------------------------
module waveform_peak_pyramid_top import wpp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  wpp_frame_if.sink         frame,
  wpp_bucket_if.source      bucket,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_MRG, S_CHECK, S_PLAN, S_EMIT, S_CLEAR
  } state_t;

  state_t                     state;
  logic [CC_W-1:0]            channel_count;
  logic signed [SAMPLE_W-1:0] left_q;
  logic signed [SAMPLE_W-1:0] right_q;
  logic [LANE_W-1:0]          lane_c;
  logic [LVL_W-1:0]           lvl;
  logic                       flush_mode;
  logic [LEVELS-1:0]          pend;
  logic [PCNT_W-1:0]          plan_cnt;
  logic                       plan_prev;
  bucket_t                    smp;

  // Output register
  logic               out_v;
  logic [LEVEL_W-1:0] out_level;
  logic [LANE_W-1:0]  out_lane;
  bucket_t            out_bkt;
  logic               out_last;

  // Cell chain
  cell_ctl_t  ctl  [LEVELS];
  merge_t     m_in [LEVELS];
  bucket_t    ebkt [LEVELS];
  cell_stat_t stat [LEVELS];

  logic                       two_ch;
  logic [LANE_W-1:0]          lane_last;
  logic                       cfg_hit;
  logic                       out_free;
  logic                       emit_fire;
  logic                       last_lane;
  logic                       emit_last;
  logic                       more_frame;
  logic                       pend_hi_zero;
  logic [TOTAL_W-1:0]         tot_inc;
  logic                       plan_go;
  logic                       plan_m;
  logic [LEVELS-1:0]          pend_plan;
  logic signed [SAMPLE_W:0]   mono_sum;
  logic signed [SAMPLE_W-1:0] lane_val;
  logic signed [2*SAMPLE_W-1:0] sq_prod;
  cell_stat_t                 stat_sel;
  bucket_t                    ebkt_sel;

  // Configuration port
  assign pready  = 1'b1;
  assign cfg_hit = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_CHANNEL_COUNT);
  assign prdata  = (paddr[APB_AW-1:2] == REG_CHANNEL_COUNT) ? APB_DW'(channel_count) : '0;

  assign two_ch    = channel_count[1];
  assign lane_last = two_ch ? LANE_W'(2) : LANE_W'(1);

  // Level cells
  for (genvar k = 0; k < LEVELS; k++) begin : g_cell
    assign ctl[k].emit = emit_fire && (lvl == LVL_W'(k));
    assign ctl[k].lane = lane_c;
    assign ctl[k].bump = emit_fire && (lvl == LVL_W'(k)) && last_lane && !flush_mode;
    assign ctl[k].clr  = cfg_hit || (state == S_CLEAR);

    if (k == 0) begin : g_head
      assign m_in[k].valid = (state == S_MRG);
      assign m_in[k].lane  = lane_c;
      assign m_in[k].bkt   = smp;
    end else begin : g_link
      assign m_in[k].valid = ctl[k-1].emit;
      assign m_in[k].lane  = ctl[k-1].lane;
      assign m_in[k].bkt   = ebkt[k-1];
    end

    wpp_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (ctl[k]),
      .merge_in (m_in[k]),
      .emit_bkt (ebkt[k]),
      .stat     (stat[k])
    );
  end

  assign stat_sel = stat[lvl];
  assign ebkt_sel = ebkt[lvl];

  // Sample of the current lane and its square
  always_comb begin
    mono_sum = {left_q[SAMPLE_W-1], left_q} + {right_q[SAMPLE_W-1], right_q};
    case (lane_c)
      LANE_W'(0): lane_val = left_q;
      LANE_W'(1): lane_val = two_ch ? right_q : left_q;
      default:    lane_val = mono_sum[SAMPLE_W:1];
    endcase
    sq_prod = lane_val * lane_val;
  end

  // Emission control
  assign out_free     = !out_v || bucket.ready;
  assign emit_fire    = (state == S_EMIT) && !(flush_mode && !pend[0]) && out_free;
  assign last_lane    = (lane_c == lane_last);
  assign tot_inc      = stat_sel.totals + TOTAL_W'(1);
  assign more_frame   = (lvl != LVL_W'(LEVELS-1)) && (tot_inc[FOLD_W-1:0] == '0);
  assign pend_hi_zero = ((pend >> 1) == '0);
  assign emit_last    = last_lane && (flush_mode ? pend_hi_zero : !more_frame);

  // Flush planning: which levels hold a bucket worth emitting
  assign plan_go   = (plan_cnt > PCNT_W'(1));
  assign plan_m    = stat_sel.nonempty || plan_prev;
  assign pend_plan = pend | (LEVELS'(plan_m) << lvl);

  assign frame.ready = (state == S_IDLE);

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      channel_count <= CC_RESET;
      out_v         <= 1'b0;
      flush_mode    <= 1'b0;
    end else begin
      if (cfg_hit) channel_count <= pwdata[CC_W-1:0];

      if (bucket.ready) out_v <= 1'b0;
      if (emit_fire) begin
        out_v     <= 1'b1;
        out_level <= LEVEL_W'(lvl);
        out_lane  <= lane_c;
        out_bkt   <= ebkt_sel;
        out_last  <= emit_last;
      end

      unique case (state)
        S_IDLE: begin
          if (frame.valid) begin
            if (frame.cmd == CMD_FRAME) begin
              left_q  <= frame.left_sample;
              right_q <= frame.right_sample;
              lane_c  <= '0;
              state   <= S_SQ;
            end else begin
              plan_cnt  <= PCNT_W'(2);
              plan_prev <= 1'b0;
              pend      <= '0;
              lvl       <= '0;
              state     <= S_PLAN;
            end
          end
        end
        S_SQ: begin
          smp.mn <= lane_val;
          smp.mx <= lane_val;
          smp.sq <= {{(SQ_W-2*SAMPLE_W){1'b0}}, sq_prod};
          smp.n  <= CNT_W'(1);
          state  <= S_MRG;
        end
        S_MRG: begin
          if (last_lane) begin
            state <= S_CHECK;
          end else begin
            lane_c <= lane_c + LANE_W'(1);
            state  <= S_SQ;
          end
        end
        S_CHECK: begin
          if (stat[0].full) begin
            lvl        <= '0;
            lane_c     <= '0;
            flush_mode <= 1'b0;
            state      <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_PLAN: begin
          if (plan_go) begin
            pend      <= pend_plan;
            plan_cnt  <= {1'b0, stat_sel.totals} + PCNT_W'(plan_m);
            plan_prev <= plan_m;
          end
          if (!plan_go || lvl == LVL_W'(LEVELS-1)) begin
            lvl        <= '0;
            lane_c     <= '0;
            flush_mode <= 1'b1;
            state      <= (((plan_go ? pend_plan : pend)) == '0) ? S_CLEAR : S_EMIT;
          end else begin
            lvl <= lvl + LVL_W'(1);
          end
        end
        S_EMIT: begin
          if (flush_mode && !pend[0]) begin
            // level with nothing to emit on flush
            lvl  <= lvl + LVL_W'(1);
            pend <= pend >> 1;
          end else if (emit_fire) begin
            if (!last_lane) begin
              lane_c <= lane_c + LANE_W'(1);
            end else if (emit_last) begin
              state <= flush_mode ? S_CLEAR : S_IDLE;
            end else begin
              lvl    <= lvl + LVL_W'(1);
              pend   <= pend >> 1;
              lane_c <= '0;
            end
          end
        end
        S_CLEAR: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Bucket channel
  assign bucket.valid       = out_v;
  assign bucket.level       = out_level;
  assign bucket.lane        = out_lane;
  assign bucket.bucket_min  = out_bkt.mn;
  assign bucket.bucket_max  = out_bkt.mx;
  assign bucket.square_sum  = out_bkt.sq;
  assign bucket.frame_count = out_bkt.n;
  assign bucket.last        = out_last;

  // Checks
  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    emit_fire |-> ebkt_sel.n != '0)
    else $error("empty bucket emitted");

  a_idle_not_full: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !stat[0].full)
    else $error("level 0 bucket left full while idle");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |=> !stat[0].nonempty && stat[0].totals == '0)
    else $error("pyramid not empty after flush");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    emit_fire && emit_last |=> state == S_IDLE || state == S_CLEAR)
    else $error("sequencer kept running after final bucket");

endmodule
